// ----- rtl/core/glyph_cell_renderer_assert.svh -----
// Assertion macros for the glyph cell renderer checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef GLYPH_CELL_RENDERER_ASSERT_SVH
`define GLYPH_CELL_RENDERER_ASSERT_SVH

// same-cycle implication
`define GCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glyph cell renderer: assertion failed");

// next-cycle implication
`define GCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glyph cell renderer: assertion failed");

`endif

// ----- rtl/core/gcr_pkg.sv -----
// Shared constants, register and format codes, and types of the glyph cell renderer.
// No dependencies.
package gcr_pkg;

  localparam int FONT_WIDTH  = 8;
  localparam int FONT_HEIGHT = 16;
  localparam int CELL_SCALE  = 2;

  localparam int CELL_W = FONT_WIDTH * CELL_SCALE;
  localparam int CELL_H = FONT_HEIGHT * CELL_SCALE;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int LINE_W     = 5;
  localparam int BITS_W     = 16;
  localparam int COLOR_W    = 32;
  localparam int OFFSET_W   = 29;
  localparam int NBYTES_W   = 3;
  localparam int DIM_W      = 14;
  localparam int PITCH_W    = 17;
  localparam int FMT_W      = 3;
  localparam int LAYOUT_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // pixel counters inside one glyph row
  localparam int GX_W  = (FONT_WIDTH > 1) ? $clog2(FONT_WIDTH) : 1;
  localparam int SC_W  = (CELL_SCALE > 1) ? $clog2(CELL_SCALE) : 1;
  localparam int X_W   = (CELL_W > 1) ? $clog2(CELL_W) : 1;
  localparam int XB_W  = X_W + NBYTES_W;
  localparam int OXB_W = COL_W + X_W + NBYTES_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_ROW_PITCH      = 3'd2,
    REG_PIXEL_FORMAT   = 3'd3,
    REG_RED_LAYOUT     = 3'd4,
    REG_GREEN_LAYOUT   = 3'd5,
    REG_BLUE_LAYOUT    = 3'd6,
    REG_CONSOLE_LOCKED = 3'd7
  } gcr_reg_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_RAW16 = 3'd0,
    FMT_RAW24 = 3'd1,
    FMT_RAW32 = 3'd2,
    FMT_RGB16 = 3'd3,
    FMT_RGB24 = 3'd4,
    FMT_RGB32 = 3'd5
  } gcr_fmt_e;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [PITCH_W-1:0]  row_pitch;
    logic [FMT_W-1:0]    pixel_format;
    logic [LAYOUT_W-1:0] red_layout;
    logic [LAYOUT_W-1:0] green_layout;
    logic [LAYOUT_W-1:0] blue_layout;
    logic                console_locked;
  } gcr_cfg_t;

  // one glyph row ready to be written out
  typedef struct packed {
    logic [OFFSET_W-1:0]   base;
    logic [COLOR_W-1:0]    fore_data;
    logic [COLOR_W-1:0]    back_data;
    logic [FONT_WIDTH-1:0] bits;
    logic [NBYTES_W-1:0]   nbytes;
  } gcr_job_t;

endpackage

// ----- rtl/core/gcr_front.sv -----
// Front end: accepts glyph rows, drops those that give no writes, packs colors
// and computes the base byte offset. Depends on gcr_pkg.
module gcr_front import gcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcr_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [COL_W-1:0]  cell_column_i,
  input  logic [ROW_W-1:0]  cell_row_i,
  input  logic [LINE_W-1:0] glyph_line_i,
  input  logic [BITS_W-1:0] glyph_bits_i,
  input  logic [COLOR_W-1:0] fore_color_i,
  input  logic [COLOR_W-1:0] back_color_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output gcr_job_t          job_o
);

  localparam int YE_W   = ROW_W + $clog2(CELL_H + 1) + 1;
  localparam int PROD_W = DIM_W + PITCH_W;

  function automatic logic [COLOR_W-1:0] pack_chan(logic [7:0] v, logic [LAYOUT_W-1:0] layout);
    logic [5:0] sz;
    logic [3:0] s8;
    logic [7:0] t;
    sz = layout[10:5];
    s8 = (sz > 6'd8) ? 4'd8 : sz[3:0];
    t  = v >> (4'd8 - s8);  // size zero shifts everything out
    return COLOR_W'(t) << layout[4:0];
  endfunction

  function automatic logic [COLOR_W-1:0] make_data(logic [COLOR_W-1:0] color, logic rgb,
                                                   logic [NBYTES_W-1:0] nb,
                                                   gcr_cfg_t cfg);
    logic [COLOR_W-1:0] d;
    d = color;
    if (rgb) begin
      d = pack_chan(color[23:16], cfg.red_layout) |
          pack_chan(color[15:8], cfg.green_layout) |
          pack_chan(color[7:0], cfg.blue_layout);
    end
    case (nb)
      3'd2:    d = d & 32'h0000_ffff;
      3'd3:    d = d & 32'h00ff_ffff;
      default: d = d;
    endcase
    return d;
  endfunction

  logic [DIM_W-1:0]    grid_cols;
  logic [DIM_W-1:0]    grid_rows;
  logic                fmt_ok;
  logic                rgb;
  logic [NBYTES_W-1:0] nbytes;
  logic                keep;
  logic [YE_W-1:0]     y_full;
  logic [OXB_W-1:0]    oxb;
  logic                s1_adv;
  logic                s2_adv;
  logic [PROD_W-1:0]   prod_full;

  logic                s1_valid_q;
  logic [DIM_W-1:0]    s1_y_q;
  logic [OXB_W-1:0]    s1_oxb_q;
  gcr_job_t            s1_job_q;
  logic                s2_valid_q;
  logic [OXB_W-1:0]    s2_oxb_q;
  gcr_job_t            s2_job_q;

  assign grid_cols = DIM_W'(cfg_i.frame_width / CELL_W);
  assign grid_rows = DIM_W'(cfg_i.frame_height / CELL_H);

  always_comb begin
    fmt_ok = 1'b1;
    nbytes = 3'd4;
    case (cfg_i.pixel_format) inside
      FMT_RAW16, FMT_RGB16: nbytes = 3'd2;
      FMT_RAW24, FMT_RGB24: nbytes = 3'd3;
      FMT_RAW32, FMT_RGB32: nbytes = 3'd4;
      default:              fmt_ok = 1'b0;
    endcase
  end

  assign rgb  = cfg_i.pixel_format >= FMT_RGB16;
  assign keep = !cfg_i.console_locked && fmt_ok &&
                (DIM_W'(cell_column_i) < grid_cols) &&
                (DIM_W'(cell_row_i) < grid_rows) &&
                ((LINE_W + 1)'(glyph_line_i) < (LINE_W + 1)'(FONT_HEIGHT));

  // a kept cell lies inside the frame, so its top line fits DIM_W bits
  assign y_full = YE_W'(cell_row_i) * YE_W'(CELL_H) +
                  YE_W'(glyph_line_i) * YE_W'(CELL_SCALE);
  assign oxb    = OXB_W'(cell_column_i) * OXB_W'(CELL_W) * OXB_W'(nbytes);

  assign s2_adv     = !s2_valid_q || job_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  assign prod_full = PROD_W'(s1_y_q) * PROD_W'(cfg_i.row_pitch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i && keep;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_y_q             <= y_full[DIM_W-1:0];
      s1_oxb_q           <= oxb;
      s1_job_q.base      <= '0;
      s1_job_q.fore_data <= make_data(fore_color_i, rgb, nbytes, cfg_i);
      s1_job_q.back_data <= make_data(back_color_i, rgb, nbytes, cfg_i);
      s1_job_q.bits      <= glyph_bits_i[FONT_WIDTH-1:0];
      s1_job_q.nbytes    <= nbytes;
    end
    if (s2_adv && s1_valid_q) begin
      s2_job_q.base      <= prod_full[OFFSET_W-1:0];
      s2_job_q.fore_data <= s1_job_q.fore_data;
      s2_job_q.back_data <= s1_job_q.back_data;
      s2_job_q.bits      <= s1_job_q.bits;
      s2_job_q.nbytes    <= s1_job_q.nbytes;
      s2_oxb_q           <= s1_oxb_q;
    end
  end

  always_comb begin
    job_o      = s2_job_q;
    job_o.base = s2_job_q.base + OFFSET_W'(s2_oxb_q);
  end
  assign job_valid_o = s2_valid_q;

endmodule

// ----- rtl/core/gcr_queue.sv -----
// Short FIFO of glyph row jobs between the front end and the write sequencer.
// Depends on gcr_pkg.
module gcr_queue import gcr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  gcr_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output gcr_job_t pop_job_o
);

  gcr_job_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                push;
  logic                pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_job_i;
  end

endmodule

// ----- rtl/core/gcr_back.sv -----
// Write sequencer: walks glyph column, scale row and scale column of one job,
// one word per unstalled cycle into an output register. Depends on gcr_pkg.
module gcr_back import gcr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PITCH_W-1:0]   row_pitch_i,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  gcr_job_t             job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OFFSET_W-1:0]  byte_offset_o,
  output logic [COLOR_W-1:0]   write_data_o,
  output logic [NBYTES_W-1:0]  write_bytes_o,
  output logic                 last_write_o
);

  logic                busy_q, busy_d;
  logic                out_valid_q, out_valid_d;
  logic [GX_W-1:0]     gx_q, gx_d;
  logic [SC_W-1:0]     sy_q, sy_d;
  logic [SC_W-1:0]     sx_q, sx_d;
  gcr_job_t            job_q;
  logic [OFFSET_W-1:0] row_base_q;
  logic [OFFSET_W-1:0] byte_offset_q;
  logic [COLOR_W-1:0]  write_data_q;
  logic [NBYTES_W-1:0] write_bytes_q;
  logic                last_write_q;

  logic                step;
  logic                load;
  logic                sx_end;
  logic                sy_end;
  logic                last_pix;
  logic [X_W-1:0]      x_pos;
  logic [XB_W-1:0]     x_bytes;

  assign sx_end   = sx_q == SC_W'(CELL_SCALE - 1);
  assign sy_end   = sy_q == SC_W'(CELL_SCALE - 1);
  assign last_pix = (gx_q == GX_W'(FONT_WIDTH - 1)) && sy_end && sx_end;

  // output register frees up when empty or taken this cycle
  assign step        = busy_q && (!out_valid_q || out_ready_i);
  assign job_ready_o = !busy_q || (step && last_pix);
  assign load        = job_valid_i && job_ready_o;

  assign x_pos   = X_W'(X_W'(gx_q) * X_W'(CELL_SCALE)) + X_W'(sx_q);
  assign x_bytes = XB_W'(x_pos) * XB_W'(job_q.nbytes);

  always_comb begin
    busy_d = busy_q;
    gx_d   = gx_q;
    sy_d   = sy_q;
    sx_d   = sx_q;
    if (load) begin
      busy_d = 1'b1;
      gx_d   = '0;
      sy_d   = '0;
      sx_d   = '0;
    end else if (step) begin
      if (last_pix) begin
        busy_d = 1'b0;
      end else if (!sx_end) begin
        sx_d = sx_q + 1'b1;
      end else begin
        sx_d = '0;
        if (sy_end) begin
          sy_d = '0;
          gx_d = gx_q + 1'b1;
        end else begin
          sy_d = sy_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (step)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      gx_q        <= '0;
      sy_q        <= '0;
      sx_q        <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      gx_q        <= gx_d;
      sy_q        <= sy_d;
      sx_q        <= sx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q      <= job_i;
      row_base_q <= job_i.base;
    end else if (step && !last_pix && sx_end) begin
      // next scale row, or back to the top line at the next glyph column
      row_base_q <= sy_end ? job_q.base : row_base_q + OFFSET_W'(row_pitch_i);
    end
    if (step) begin
      byte_offset_q <= row_base_q + OFFSET_W'(x_bytes);
      write_data_q  <= job_q.bits[gx_q] ? job_q.fore_data : job_q.back_data;
      write_bytes_q <= job_q.nbytes;
      last_write_q  <= last_pix;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_offset_o = byte_offset_q;
  assign write_data_o  = write_data_q;
  assign write_bytes_o = write_bytes_q;
  assign last_write_o  = last_write_q;

endmodule

// ----- rtl/core/glyph_cell_renderer.sv -----
// An accepted glyph row goes through the front-end stages, job queue and write sequencer.
// Throughput: FONT_WIDTH * CELL_SCALE * CELL_SCALE writes (32) per row, one per cycle
// while the output is not stalled, set by the write sequencer; a dropped row gives no writes.
// Reset: configuration registers return to their defaults, pipeline and job queue are emptied.
// Top level of the glyph cell renderer: configuration registers, front end,
// job queue and write sequencer. Depends on gcr_pkg, gcr_front, gcr_queue, gcr_back.
module glyph_cell_renderer import gcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COL_W-1:0]      cell_column_i,
  input  logic [ROW_W-1:0]      cell_row_i,
  input  logic [LINE_W-1:0]     glyph_line_i,
  input  logic [BITS_W-1:0]     glyph_bits_i,
  input  logic [COLOR_W-1:0]    fore_color_i,
  input  logic [COLOR_W-1:0]    back_color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OFFSET_W-1:0]   byte_offset_o,
  output logic [COLOR_W-1:0]    write_data_o,
  output logic [NBYTES_W-1:0]   write_bytes_o,
  output logic                  last_write_o
);

  gcr_cfg_t cfg_q;
  logic     fj_valid;
  logic     fj_ready;
  gcr_job_t fj_job;
  logic     qj_valid;
  logic     qj_ready;
  gcr_job_t qj_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= DIM_W'(1024);
      cfg_q.frame_height   <= DIM_W'(768);
      cfg_q.row_pitch      <= PITCH_W'(4096);
      cfg_q.pixel_format   <= FMT_RGB32;
      cfg_q.red_layout     <= LAYOUT_W'(272);
      cfg_q.green_layout   <= LAYOUT_W'(264);
      cfg_q.blue_layout    <= LAYOUT_W'(256);
      cfg_q.console_locked <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (gcr_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i[DIM_W-1:0];
        REG_ROW_PITCH:      cfg_q.row_pitch      <= cfg_data_i[PITCH_W-1:0];
        REG_PIXEL_FORMAT:   cfg_q.pixel_format   <= cfg_data_i[FMT_W-1:0];
        REG_RED_LAYOUT:     cfg_q.red_layout     <= cfg_data_i[LAYOUT_W-1:0];
        REG_GREEN_LAYOUT:   cfg_q.green_layout   <= cfg_data_i[LAYOUT_W-1:0];
        REG_BLUE_LAYOUT:    cfg_q.blue_layout    <= cfg_data_i[LAYOUT_W-1:0];
        REG_CONSOLE_LOCKED: cfg_q.console_locked <= cfg_data_i[0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  gcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_column_i(cell_column_i),
    .cell_row_i   (cell_row_i),
    .glyph_line_i (glyph_line_i),
    .glyph_bits_i (glyph_bits_i),
    .fore_color_i (fore_color_i),
    .back_color_i (back_color_i),
    .job_valid_o  (fj_valid),
    .job_ready_i  (fj_ready),
    .job_o        (fj_job)
  );

  gcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fj_valid),
    .push_ready_o(fj_ready),
    .push_job_i  (fj_job),
    .pop_valid_o (qj_valid),
    .pop_ready_i (qj_ready),
    .pop_job_o   (qj_job)
  );

  gcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_pitch_i  (cfg_q.row_pitch),
    .job_valid_i  (qj_valid),
    .job_ready_o  (qj_ready),
    .job_i        (qj_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_offset_o(byte_offset_o),
    .write_data_o (write_data_o),
    .write_bytes_o(write_bytes_o),
    .last_write_o (last_write_o)
  );

endmodule

// ----- rtl/core/gcr_checker.sv -----
// Port-level checks of the glyph cell renderer, bound to the top level.
// Depends on gcr_pkg and glyph_cell_renderer_assert.svh.
`include "glyph_cell_renderer_assert.svh"

module gcr_checker import gcr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [OFFSET_W-1:0]   byte_offset_o,
  input logic [COLOR_W-1:0]    write_data_o,
  input logic [NBYTES_W-1:0]   write_bytes_o,
  input logic                  last_write_o
);

  logic                                       out_fire;
  logic                                       out_stall;
  logic                                       mid_fire;
  logic                                       bytes_ok;
  logic                                       data_masked;
  logic [OFFSET_W+COLOR_W+NBYTES_W:0]         out_word;

  assign out_fire    = out_valid_o && out_ready_i;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign mid_fire    = out_fire && !last_write_o;
  assign bytes_ok    = (write_bytes_o == 3'd2) || (write_bytes_o == 3'd3) ||
                       (write_bytes_o == 3'd4);
  assign data_masked = (write_bytes_o != 3'd2 || write_data_o[31:16] == 16'h0) &&
                       (write_bytes_o != 3'd3 || write_data_o[31:24] == 8'h0);
  assign out_word    = {byte_offset_o, write_data_o, write_bytes_o, last_write_o};

  `GCR_ASSERT_NXT(a_out_hold, out_stall, out_valid_o)
  `GCR_ASSERT_NXT(a_out_stable, out_stall, $stable(out_word))
  `GCR_ASSERT_IMP(a_bytes_legal, out_valid_o, bytes_ok)
  `GCR_ASSERT_IMP(a_data_masked, out_valid_o, data_masked)
  // words of one glyph row share their width
  `GCR_ASSERT_NXT(a_same_row_bytes, mid_fire, !out_fire || $stable(write_bytes_o))

endmodule

bind glyph_cell_renderer gcr_checker u_gcr_checker (.*);

// ----- tb/sv/glyph_cell_renderer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for glyph_cell_renderer: a directed table, then random glyph rows
// under several register settings and handshake stall patterns. Depends on gcr_pkg.
module glyph_cell_renderer_tb;
  import gcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_ROWS     = 11;
  localparam int FROM_MODEL     = -1;
  localparam int FMT_RESERVED6  = 6;
  localparam int FMT_RESERVED7  = 7;

  typedef enum logic {ROW_GLYPH, ROW_REG} row_kind_e;

  typedef struct packed {
    logic [COL_W-1:0]   cell_column;
    logic [ROW_W-1:0]   cell_row;
    logic [LINE_W-1:0]  glyph_line;
    logic [BITS_W-1:0]  glyph_bits;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
  } glyph_row_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  write_data;
    logic [NBYTES_W-1:0] write_bytes;
    logic                last_write;
  } pixel_write_t;

  typedef struct {
    row_kind_e    kind;
    gcr_reg_e     reg_idx;
    int           reg_val;
    glyph_row_t   glyph;
    int           exp_n;      // 0 for no writes, else writes from the model
    logic [31:0]  exp_data;   // uniform data when exp_n > 0
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [COL_W-1:0]      cell_column_i;
  logic [ROW_W-1:0]      cell_row_i;
  logic [LINE_W-1:0]     glyph_line_i;
  logic [BITS_W-1:0]     glyph_bits_i;
  logic [COLOR_W-1:0]    fore_color_i;
  logic [COLOR_W-1:0]    back_color_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b1;
  logic [OFFSET_W-1:0]   byte_offset_o;
  logic [COLOR_W-1:0]    write_data_o;
  logic [NBYTES_W-1:0]   write_bytes_o;
  logic                  last_write_o;

  gcr_cfg_t     fb_cfg;
  pixel_write_t pending_pixels[$];
  stim_row_t    directed_rows[$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  glyph_cell_renderer uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pixel predictor

  function automatic logic [COLOR_W-1:0] scale_channel(logic [7:0] level,
                                                       logic [LAYOUT_W-1:0] layout);
    int size;
    logic [COLOR_W-1:0] v;
    size = int'(layout[10:5]);
    if (size == 0) return '0;
    if (size > 8) size = 8;
    // keep the top size bits of the 8-bit channel
    v = COLOR_W'(level >> (8 - size));
    return v << layout[4:0];
  endfunction

  function automatic logic [COLOR_W-1:0] color_word(logic [COLOR_W-1:0] color, bit rgb, int nb);
    logic [COLOR_W-1:0] d;
    d = color;
    if (rgb)
      d = scale_channel(color[23:16], fb_cfg.red_layout) |
          scale_channel(color[15:8], fb_cfg.green_layout) |
          scale_channel(color[7:0], fb_cfg.blue_layout);
    if (nb == 2) d[31:16] = '0;
    else if (nb == 3) d[31:24] = '0;
    return d;
  endfunction

  // queues every framebuffer write of one glyph row; returns how many
  function automatic int expand_glyph_row(glyph_row_t r);
    pixel_write_t w;
    int nb, cols, rows, x, y, n;
    bit rgb;
    longint off;
    logic [COLOR_W-1:0] fore_d, back_d;
    n = 0;
    if (fb_cfg.console_locked) return 0;
    case (fb_cfg.pixel_format)
      FMT_RAW16: begin nb = 2; rgb = 1'b0; end
      FMT_RAW24: begin nb = 3; rgb = 1'b0; end
      FMT_RAW32: begin nb = 4; rgb = 1'b0; end
      FMT_RGB16: begin nb = 2; rgb = 1'b1; end
      FMT_RGB24: begin nb = 3; rgb = 1'b1; end
      FMT_RGB32: begin nb = 4; rgb = 1'b1; end
      default: return 0;
    endcase
    cols = int'(fb_cfg.frame_width) / CELL_W;
    rows = int'(fb_cfg.frame_height) / CELL_H;
    if (int'(r.cell_column) >= cols || int'(r.cell_row) >= rows) return 0;
    if (int'(r.glyph_line) >= FONT_HEIGHT) return 0;
    fore_d = color_word(r.fore_color, rgb, nb);
    back_d = color_word(r.back_color, rgb, nb);
    for (int gx = 0; gx < FONT_WIDTH; gx++) begin
      for (int sy = 0; sy < CELL_SCALE; sy++) begin
        for (int sx = 0; sx < CELL_SCALE; sx++) begin
          x = int'(r.cell_column) * CELL_W + gx * CELL_SCALE + sx;
          y = int'(r.cell_row) * CELL_H + int'(r.glyph_line) * CELL_SCALE + sy;
          if (x >= int'(fb_cfg.frame_width) || y >= int'(fb_cfg.frame_height)) continue;
          off = longint'(y) * longint'(fb_cfg.row_pitch) + longint'(x * nb);
          w.byte_offset = OFFSET_W'(off);
          w.write_data  = r.glyph_bits[gx] ? fore_d : back_d;
          w.write_bytes = NBYTES_W'(nb);
          w.last_write  = 1'b0;
          pending_pixels.push_back(w);
          n++;
        end
      end
    end
    if (n > 0) pending_pixels[pending_pixels.size() - 1].last_write = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // checking

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin
    pixel_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("write word with none pending: offset %h data %h",
                             byte_offset_o, write_data_o));
      end else begin
        want = pending_pixels.pop_front();
        if (byte_offset_o !== want.byte_offset)
          note_error($sformatf("byte_offset exp %h got %h", want.byte_offset, byte_offset_o));
        if (write_data_o !== want.write_data)
          note_error($sformatf("write_data exp %h got %h", want.write_data, write_data_o));
        if (write_bytes_o !== want.write_bytes)
          note_error($sformatf("write_bytes exp %0d got %0d", want.write_bytes, write_bytes_o));
        if (last_write_o !== want.last_write)
          note_error($sformatf("last_write exp %0b got %0b", want.last_write, last_write_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends at a falling edge

  task automatic send_glyph(input glyph_row_t r, input int exp_n, input logic [31:0] exp_data,
                            output int n);
    int first;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cell_column_i <= r.cell_column;
    cell_row_i    <= r.cell_row;
    glyph_line_i  <= r.glyph_line;
    glyph_bits_i  <= r.glyph_bits;
    fore_color_i  <= r.fore_color;
    back_color_i  <= r.back_color;
    do @(posedge clk_i); while (!in_ready_o);
    first = pending_pixels.size();
    n = 0;
    if (exp_n != 0) n = expand_glyph_row(r);
    if (exp_n > 0)
      for (int i = first; i < pending_pixels.size(); i++) pending_pixels[i].write_data = exp_data;
    @(negedge clk_i);
  endtask

  // a wrongly kept row may still be in the pipe after the last word, hence the settle time
  task automatic drain_writes();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input gcr_reg_e idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    @(negedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:    fb_cfg.frame_width    = DIM_W'(val);
      REG_FRAME_HEIGHT:   fb_cfg.frame_height   = DIM_W'(val);
      REG_ROW_PITCH:      fb_cfg.row_pitch      = PITCH_W'(val);
      REG_PIXEL_FORMAT:   fb_cfg.pixel_format   = FMT_W'(val);
      REG_RED_LAYOUT:     fb_cfg.red_layout     = LAYOUT_W'(val);
      REG_GREEN_LAYOUT:   fb_cfg.green_layout   = LAYOUT_W'(val);
      REG_BLUE_LAYOUT:    fb_cfg.blue_layout    = LAYOUT_W'(val);
      REG_CONSOLE_LOCKED: fb_cfg.console_locked = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input int fw, input int fh, input int pitch, input int fmt,
                             input int red, input int green, input int blue);
    drain_writes();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_ROW_PITCH, pitch);
    write_reg(REG_PIXEL_FORMAT, fmt);
    write_reg(REG_RED_LAYOUT, red);
    write_reg(REG_GREEN_LAYOUT, green);
    write_reg(REG_BLUE_LAYOUT, blue);
    write_reg(REG_CONSOLE_LOCKED, 0);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_config();
    load_config($urandom_range(8192, CELL_W), $urandom_range(8192, CELL_H),
                $urandom_range(65536, 1), $urandom_range(int'(FMT_RGB32), int'(FMT_RAW16)),
                $urandom_range(2047), $urandom_range(2047), $urandom_range(2047));
  endtask

  // mostly rows inside the grid, some noise over the whole field ranges
  task automatic run_phase(input int live_rows);
    glyph_row_t r;
    int live, cols, rows, n;
    live = 0;
    cols = int'(fb_cfg.frame_width) / CELL_W;
    rows = int'(fb_cfg.frame_height) / CELL_H;
    while (live < live_rows) begin
      r.glyph_bits = BITS_W'($urandom);
      r.fore_color = $urandom;
      r.back_color = $urandom;
      if ($urandom_range(99) < 15) begin
        r.cell_column = COL_W'($urandom);
        r.cell_row    = ROW_W'($urandom);
        r.glyph_line  = LINE_W'($urandom);
      end else begin
        r.cell_column = COL_W'($urandom_range(cols - 1));
        r.cell_row    = ROW_W'($urandom_range(rows - 1));
        r.glyph_line  = LINE_W'($urandom_range(FONT_HEIGHT - 1));
      end
      send_glyph(r, FROM_MODEL, '0, n);
      if (n > 0) live++;
    end
  endtask

  function automatic void add_glyph(int col, int row, int line, int bits,
                                    logic [31:0] fg, logic [31:0] bg,
                                    int exp_n, logic [31:0] exp_data);
    stim_row_t s;
    s.kind = ROW_GLYPH;
    s.reg_idx = REG_FRAME_WIDTH;
    s.reg_val = 0;
    s.glyph = '{COL_W'(col), ROW_W'(row), LINE_W'(line), BITS_W'(bits), fg, bg};
    s.exp_n = exp_n;
    s.exp_data = exp_data;
    directed_rows.push_back(s);
  endfunction

  function automatic void add_reg(gcr_reg_e idx, int val);
    stim_row_t s;
    s.kind = ROW_REG;
    s.reg_idx = idx;
    s.reg_val = val;
    s.glyph = '0;
    s.exp_n = 0;
    s.exp_data = '0;
    directed_rows.push_back(s);
  endfunction

  function automatic int chan_layout(int size, int shift);
    return size * 32 + shift;
  endfunction

  // ---------------------------------------------------------------------------

  initial begin
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cell_column_i = '0;
    cell_row_i = '0;
    glyph_line_i = '0;
    glyph_bits_i = '0;
    fore_color_i = '0;
    back_color_i = '0;
    fb_cfg = '{14'd1024, 14'd768, 17'd4096, FMT_RGB32, 11'd272, 11'd264, 11'd256, 1'b0};

    // reset state: RGB32, 8-bit channels at 16/8/0, grid of 64 x 24 cells
    add_glyph(0, 0, 0, 'h00ff, 32'h00123456, 32'h0, 32, 32'h00123456);
    add_glyph(63, 23, 15, 'hff00, '1, 32'hffabcdef, 32, 32'h00abcdef);  // high bits ignored
    add_glyph(64, 0, 0, 'h00ff, '1, '1, 0, '0);                         // column past grid
    add_glyph(0, 24, 0, 'h00ff, '1, '1, 0, '0);                         // row past grid
    add_glyph(1023, 1023, 31, 'hffff, '1, '1, 0, '0);
    add_glyph(5, 7, 16, 'h0081, '1, '0, 0, '0);                         // line past font
    add_glyph(10, 3, 9, 'h00a5, 32'h00f0e1d2, 32'h000f1e2d, FROM_MODEL, '0);
    add_reg(REG_PIXEL_FORMAT, FMT_RAW16);
    add_glyph(1, 1, 1, 'h005a, '1, 32'h12345678, FROM_MODEL, '0);
    add_glyph(2, 2, 2, 'h00ff, 32'hdeadbeef, '0, 32, 32'h0000beef);
    add_reg(REG_PIXEL_FORMAT, FMT_RAW24);
    add_glyph(3, 4, 5, 'h0000, '0, 32'hcafef00d, 32, 32'h00fef00d);
    add_reg(REG_PIXEL_FORMAT, FMT_RAW32);
    add_glyph(0, 0, 15, 'hffff, '1, '0, 32, '1);
    add_reg(REG_PIXEL_FORMAT, FMT_RESERVED6);
    add_glyph(0, 0, 0, 'h00f0, '1, '1, 0, '0);
    add_reg(REG_PIXEL_FORMAT, FMT_RESERVED7);
    add_glyph(0, 0, 0, 'h000f, '1, '1, 0, '0);
    // zero-size red, oversize green at the top bit, narrow blue
    add_reg(REG_PIXEL_FORMAT, FMT_RGB16);
    add_reg(REG_RED_LAYOUT, chan_layout(0, 31));
    add_reg(REG_GREEN_LAYOUT, chan_layout(63, 31));
    add_reg(REG_BLUE_LAYOUT, chan_layout(4, 5));
    add_glyph(4, 5, 6, 'h003c, 32'h00ffffff, 32'h00808080, FROM_MODEL, '0);
    add_reg(REG_PIXEL_FORMAT, FMT_RGB24);
    add_reg(REG_RED_LAYOUT, chan_layout(3, 21));
    add_glyph(6, 8, 10, 'h00c3, 32'h00b7e15a, 32'h004d2c91, FROM_MODEL, '0);
    add_reg(REG_PIXEL_FORMAT, FMT_RGB32);
    add_glyph(7, 9, 11, 'h0099, 32'hff81ff01, 32'h007f00fe, FROM_MODEL, '0);
    add_reg(REG_CONSOLE_LOCKED, 1);
    add_glyph(0, 0, 0, 'h00ff, '1, '1, 0, '0);
    add_reg(REG_CONSOLE_LOCKED, 0);
    add_reg(REG_FRAME_WIDTH, CELL_W - 1);    // grid zero columns wide
    add_glyph(0, 0, 0, 'h00ff, '1, '1, 0, '0);
    add_reg(REG_FRAME_WIDTH, CELL_W);
    add_reg(REG_FRAME_HEIGHT, CELL_H - 1);   // grid zero rows high
    add_glyph(0, 0, 0, 'h00ff, '1, '1, 0, '0);
    add_reg(REG_FRAME_HEIGHT, CELL_H);
    add_reg(REG_ROW_PITCH, 1);
    add_glyph(0, 0, 15, 'h0055, 32'h01020304, 32'hf0e0d0c0, FROM_MODEL, '0);
    add_reg(REG_FRAME_WIDTH, 8192);
    add_reg(REG_FRAME_HEIGHT, 8192);
    add_reg(REG_ROW_PITCH, 65536);
    add_glyph(511, 255, 15, 'h0081, 32'h00ffffff, 32'h00000001, FROM_MODEL, '0);
    add_glyph(512, 255, 15, 'h0081, '1, '1, 0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_writes();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        cfg_we_i <= 1'b0;
      end else begin
        send_glyph(directed_rows[i].glyph, directed_rows[i].exp_n,
                   directed_rows[i].exp_data, n);
      end
    end

    load_config(1024, 768, 4096, FMT_RGB32, 272, 264, 256);
    run_phase(PHASE_ROWS);

    send_idle_pct = 77;
    load_config(8192, 8192, 65536, FMT_RAW32, 0, 0, 0);
    run_phase(PHASE_ROWS);

    // 565 layout
    send_idle_pct = 0;
    recv_stall_pct = 77;
    load_config(640, 480, 1280, FMT_RGB16, chan_layout(5, 11), chan_layout(6, 5),
                chan_layout(5, 0));
    run_phase(PHASE_ROWS);

    send_idle_pct = 6;
    recv_stall_pct = 6;
    load_random_config();
    run_phase(PHASE_ROWS);

    // single cell, tightest pitch, every layout field at its top
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_config(CELL_W, CELL_H, 1, FMT_RGB24, 2047, 2047, 2047);
    run_phase(PHASE_ROWS);

    send_idle_pct = 77;
    load_random_config();
    run_phase(PHASE_ROWS);

    send_idle_pct = 0;
    recv_stall_pct = 77;
    load_random_config();
    run_phase(PHASE_ROWS);

    send_idle_pct = 6;
    recv_stall_pct = 6;
    load_random_config();
    run_phase(PHASE_ROWS);

    drain_writes();
    if (pending_pixels.size() != 0) note_error("writes still pending at end of run");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
